FILE: rtl/core/stepper_pid_step_generator_macros.svh
// Assertion macros shared by the step generator RTL.
`ifndef STEPPER_PID_STEP_GENERATOR_MACROS_SVH
`define STEPPER_PID_STEP_GENERATOR_MACROS_SVH

// Condition must hold on every clock out of reset.
`define SPSG_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent on the next clock.
`define SPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/spsg_pkg.sv
// Types, constants and saturation helpers for the step generator.
`default_nettype none
package spsg_pkg;

  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = 6;
  localparam int PROD_W    = 97;

  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  localparam logic [63:0] MICRO     = 64'd1000000;
  localparam logic [63:0] ANGLE_DIV = 64'd92160;
  localparam logic [31:0] DT_ZERO   = 32'd100;
  localparam logic [63:0] MAG_MIN   = 64'd6553;
  localparam logic [63:0] S64_MAX   = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN   = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic        start;
    logic        op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
    logic [63:0]       quot;
    logic [63:0]       rem;
  } alu_rsp_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] neg_if(input logic [63:0] v, input logic neg);
    return neg ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sat_mag(input logic [PROD_W-1:0] m, input logic neg);
    if (neg) begin
      if (m > {{(PROD_W-64){1'b0}}, S64_MIN}) begin
        return S64_MIN;
      end
      return 64'd0 - m[63:0];
    end
    if (m > {{(PROD_W-64){1'b0}}, S64_MAX}) begin
      return S64_MAX;
    end
    return m[63:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/spsg_alu.sv
// Shared bit-serial multiplier and restoring divider.
`default_nettype none
module spsg_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spsg_pkg::alu_req_t req,
  output spsg_pkg::alu_rsp_t      rsp
);

  logic                          op_r, op_nxt;
  logic [63:0]                   opa_r, opa_nxt;
  logic [spsg_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [63:0]                   rem_r, rem_nxt;
  logic [63:0]                   quo_r, quo_nxt;
  logic [spsg_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [64:0]                   msum;
  logic [64:0]                   dtry;
  logic [64:0]                   dsub;
  logic                          dge;

  always_comb begin
    op_nxt   = op_r;
    opa_nxt  = opa_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    msum = {1'b0, acc_r[96:33]} + {1'b0, opa_r};
    dtry = {rem_r, quo_r[63]};
    dge  = dtry >= {1'b0, opa_r};
    dsub = dtry - {1'b0, opa_r};
    if (req.start) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      if (req.op == spsg_pkg::ALU_MUL) begin
        opa_nxt = req.a;
        acc_nxt = {64'd0, req.b[32:0]};
        cnt_nxt = spsg_pkg::CNT_W'(spsg_pkg::MUL_STEPS - 1);
      end else begin
        opa_nxt = req.b;
        rem_nxt = 64'd0;
        quo_nxt = req.a;
        cnt_nxt = spsg_pkg::CNT_W'(spsg_pkg::DIV_STEPS - 1);
      end
    end else if (busy_r) begin
      if (op_r == spsg_pkg::ALU_MUL) begin
        acc_nxt = acc_r[0] ? {msum, acc_r[32:1]} : {1'b0, acc_r[96:33], acc_r[32:1]};
      end else begin
        rem_nxt = dge ? dsub[63:0] : dtry[63:0];
        quo_nxt = {quo_r[62:0], dge};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    opa_r <= opa_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

FILE: rtl/core/stepper_pid_step_generator.sv
// Top level: PID position loop feeding a step/direction pulse generator.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | target_angle, now_us
//  out_    | output    | out_valid/out_stall | step_pulse, direction, position,
//          |           |                     | step_interval_us, at_target
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One tick runs a sequence on the shared multiply/divide unit: a multiply runs
// 33 steps, a divide 64 steps. A tick at target ends after the angle multiply
// and divide; a moving tick also runs the PID multiplies and divides, and the
// speed divide when the PID output is large enough. Input is stalled from
// transfer until the result transfers; out_stall holds the result in place.
// Synchronous reset clears the loop state and loads register defaults.
`default_nettype none
`include "stepper_pid_step_generator_macros.svh"
module stepper_pid_step_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_target_angle,
  input  wire logic [31:0] in_now_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_step_pulse,
  output logic             out_direction,
  output logic [31:0]      out_position,
  output logic [15:0]      out_step_interval_us,
  output logic             out_at_target,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam logic [2:0] R_GAIN_P = 3'd0;
  localparam logic [2:0] R_GAIN_I = 3'd1;
  localparam logic [2:0] R_GAIN_D = 3'd2;
  localparam logic [2:0] R_SPR    = 3'd3;
  localparam logic [2:0] R_MIN    = 3'd4;
  localparam logic [2:0] R_MAX    = 3'd5;
  localparam logic [2:0] R_SPEED  = 3'd6;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TSMUL = 5'd1;
  localparam logic [4:0] S_TSDIV = 5'd2;
  localparam logic [4:0] S_ERR   = 5'd3;
  localparam logic [4:0] S_IMUL  = 5'd4;
  localparam logic [4:0] S_PMUL  = 5'd5;
  localparam logic [4:0] S_IDIV  = 5'd6;
  localparam logic [4:0] S_I1    = 5'd7;
  localparam logic [4:0] S_I2    = 5'd8;
  localparam logic [4:0] S_I2D   = 5'd9;
  localparam logic [4:0] S_DMUL  = 5'd10;
  localparam logic [4:0] S_DDIV  = 5'd11;
  localparam logic [4:0] S_D1    = 5'd12;
  localparam logic [4:0] S_D2    = 5'd13;
  localparam logic [4:0] S_D2D   = 5'd14;
  localparam logic [4:0] S_SUM1  = 5'd15;
  localparam logic [4:0] S_SUM2  = 5'd16;
  localparam logic [4:0] S_MAG   = 5'd17;
  localparam logic [4:0] S_VDIV  = 5'd18;
  localparam logic [4:0] S_CLAMP = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  logic [31:0] gain_p_r, gain_i_r, gain_d_r, speed_r;
  logic [15:0] spr_r, min_r, max_r;

  logic [4:0]  state_r, state_nxt;
  logic [31:0] angle_r, angle_nxt;
  logic [31:0] now_r, now_nxt;
  logic [48:0] tstep_r, tstep_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [63:0] integ_r, integ_nxt;
  logic [63:0] pterm_r, pterm_nxt;
  logic [63:0] iterm_r, iterm_nxt;
  logic [63:0] dterm_r, dterm_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [63:0] ival_r, ival_nxt;
  logic [63:0] rmag_r, rmag_nxt;
  logic        num_neg_r, num_neg_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] last_upd_r, last_upd_nxt;
  logic [31:0] last_step_r, last_step_nxt;
  logic        dir_r, dir_nxt;
  logic        pulse_r, pulse_nxt;
  logic [15:0] intv_r, intv_nxt;
  logic        at_r, at_nxt;
  spsg_pkg::alu_req_t req_r, req_nxt;
  spsg_pkg::alu_rsp_t rsp;

  logic [49:0] err_w;
  logic [31:0] err_sat;
  logic [63:0] err_sat_mag;
  logic [31:0] dt_w;
  logic [63:0] err_mag, gp_mag, gi_mag, gd_mag, integ_mag, sum_mag;
  logic [32:0] diff, diff_mag;
  logic        gi_sgn;
  logic [63:0] iv_lo;
  logic [15:0] iv;
  logic [31:0] elapsed;

  spsg_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 32'd131072;
      gain_i_r <= 32'd0;
      gain_d_r <= 32'd32768;
      spr_r    <= 16'd2000;
      min_r    <= 16'd400;
      max_r    <= 16'd10000;
      speed_r  <= 32'd20000;
    end else if (cfg_we) begin
      case (cfg_index)
        R_GAIN_P: gain_p_r <= cfg_wdata;
        R_GAIN_I: gain_i_r <= cfg_wdata;
        R_GAIN_D: gain_d_r <= cfg_wdata;
        R_SPR:    spr_r    <= cfg_wdata[15:0];
        R_MIN:    min_r    <= cfg_wdata[15:0];
        R_MAX:    max_r    <= cfg_wdata[15:0];
        R_SPEED:  speed_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    err_w = {tstep_r[48], tstep_r} - {{18{pos_r[31]}}, pos_r};
    if (err_w[49:31] != {19{err_w[49]}}) begin
      err_sat = err_w[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      err_sat = err_w[31:0];
    end
    err_sat_mag = {32'd0, err_sat[31] ? (32'd0 - err_sat) : err_sat};
    dt_w        = now_r - last_upd_r;
    if (dt_w == 32'd0) begin
      dt_w = spsg_pkg::DT_ZERO;
    end
    err_mag   = {32'd0, err_r[31] ? (32'd0 - err_r) : err_r};
    gp_mag    = {32'd0, gain_p_r[31] ? (32'd0 - gain_p_r) : gain_p_r};
    gi_mag    = {32'd0, gain_i_r[31] ? (32'd0 - gain_i_r) : gain_i_r};
    gd_mag    = {32'd0, gain_d_r[31] ? (32'd0 - gain_d_r) : gain_d_r};
    integ_mag = spsg_pkg::neg_if(integ_r, integ_r[63]);
    diff      = {err_r[31], err_r} - {prev_r[31], prev_r};
    diff_mag  = diff[32] ? (33'd0 - diff) : diff;
    gi_sgn    = gain_i_r[31] ^ integ_r[63];
    sum_mag   = (sum_r == spsg_pkg::S64_MIN) ? spsg_pkg::S64_MAX
                                             : spsg_pkg::neg_if(sum_r, sum_r[63]);
    iv_lo     = (ival_r < {48'd0, min_r}) ? {48'd0, min_r} : ival_r;
    iv        = (iv_lo > {48'd0, max_r}) ? max_r : iv_lo[15:0];
    elapsed   = now_r - last_step_r;
  end

  always_comb begin
    state_nxt     = state_r;
    angle_nxt     = angle_r;
    now_nxt       = now_r;
    tstep_nxt     = tstep_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    integ_nxt     = integ_r;
    pterm_nxt     = pterm_r;
    iterm_nxt     = iterm_r;
    dterm_nxt     = dterm_r;
    sum_nxt       = sum_r;
    ival_nxt      = ival_r;
    rmag_nxt      = rmag_r;
    num_neg_nxt   = num_neg_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    last_upd_nxt  = last_upd_r;
    last_step_nxt = last_step_r;
    dir_nxt       = dir_r;
    pulse_nxt     = pulse_r;
    intv_nxt      = intv_r;
    at_nxt        = at_r;
    req_nxt       = req_r;
    req_nxt.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          angle_nxt = in_target_angle;
          now_nxt   = in_now_us;
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL,
                        {32'd0, in_target_angle[31] ? (32'd0 - in_target_angle)
                                                    : in_target_angle},
                        {48'd0, spr_r}};
          state_nxt = S_TSMUL;
        end
      end
      S_TSMUL: begin
        if (rsp.done) begin
          req_nxt   = '{1'b1, spsg_pkg::ALU_DIV, rsp.prod[63:0], spsg_pkg::ANGLE_DIV};
          state_nxt = S_TSDIV;
        end
      end
      S_TSDIV: begin
        if (rsp.done) begin
          tstep_nxt = angle_r[31] ? (49'd0 - {1'b0, rsp.quot[47:0]}) : {1'b0, rsp.quot[47:0]};
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        err_nxt = err_sat;
        if (err_sat == 32'd0) begin
          integ_nxt = 64'd0;
          at_nxt    = 1'b1;
          pulse_nxt = 1'b0;
          intv_nxt  = 16'd0;
          state_nxt = S_OUT;
        end else begin
          at_nxt       = 1'b0;
          dt_nxt       = dt_w;
          last_upd_nxt = now_r;
          req_nxt      = '{1'b1, spsg_pkg::ALU_MUL, err_sat_mag, {32'd0, dt_w}};
          state_nxt    = S_IMUL;
        end
      end
      S_IMUL: begin
        if (rsp.done) begin
          integ_nxt = spsg_pkg::sat_add(integ_r, spsg_pkg::neg_if(rsp.prod[63:0], err_r[31]));
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL, gp_mag, err_mag};
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        if (rsp.done) begin
          pterm_nxt = spsg_pkg::neg_if(rsp.prod[63:0], gain_p_r[31] ^ err_r[31]);
          req_nxt   = '{1'b1, spsg_pkg::ALU_DIV, integ_mag, spsg_pkg::MICRO};
          state_nxt = S_IDIV;
        end
      end
      S_IDIV: begin
        if (rsp.done) begin
          rmag_nxt  = rsp.rem;
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL, rsp.quot, gi_mag};
          state_nxt = S_I1;
        end
      end
      S_I1: begin
        if (rsp.done) begin
          iterm_nxt = spsg_pkg::sat_mag(rsp.prod, gi_sgn);
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL, rmag_r, gi_mag};
          state_nxt = S_I2;
        end
      end
      S_I2: begin
        if (rsp.done) begin
          req_nxt   = '{1'b1, spsg_pkg::ALU_DIV, rsp.prod[63:0], spsg_pkg::MICRO};
          state_nxt = S_I2D;
        end
      end
      S_I2D: begin
        if (rsp.done) begin
          iterm_nxt = spsg_pkg::sat_add(iterm_r, spsg_pkg::neg_if(rsp.quot, gi_sgn));
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL, gd_mag, {31'd0, diff_mag}};
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: begin
        if (rsp.done) begin
          num_neg_nxt = gain_d_r[31] ^ diff[32];
          req_nxt     = '{1'b1, spsg_pkg::ALU_DIV, rsp.prod[63:0], {32'd0, dt_r}};
          state_nxt   = S_DDIV;
        end
      end
      S_DDIV: begin
        if (rsp.done) begin
          rmag_nxt  = rsp.rem;
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL, rsp.quot, spsg_pkg::MICRO};
          state_nxt = S_D1;
        end
      end
      S_D1: begin
        if (rsp.done) begin
          dterm_nxt = spsg_pkg::sat_mag(rsp.prod, num_neg_r);
          req_nxt   = '{1'b1, spsg_pkg::ALU_MUL, rmag_r, spsg_pkg::MICRO};
          state_nxt = S_D2;
        end
      end
      S_D2: begin
        if (rsp.done) begin
          req_nxt   = '{1'b1, spsg_pkg::ALU_DIV, rsp.prod[63:0], {32'd0, dt_r}};
          state_nxt = S_D2D;
        end
      end
      S_D2D: begin
        if (rsp.done) begin
          dterm_nxt = spsg_pkg::sat_add(dterm_r, spsg_pkg::neg_if(rsp.quot, num_neg_r));
          state_nxt = S_SUM1;
        end
      end
      S_SUM1: begin
        sum_nxt   = spsg_pkg::sat_add(pterm_r, iterm_r);
        state_nxt = S_SUM2;
      end
      S_SUM2: begin
        sum_nxt   = spsg_pkg::sat_add(sum_r, dterm_r);
        prev_nxt  = err_r;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        dir_nxt = !sum_r[63] && (sum_r != 64'd0);
        if (sum_mag > spsg_pkg::MAG_MIN) begin
          req_nxt   = '{1'b1, spsg_pkg::ALU_DIV, {16'd0, speed_r, 16'd0}, sum_mag};
          state_nxt = S_VDIV;
        end else begin
          ival_nxt  = {48'd0, max_r};
          state_nxt = S_CLAMP;
        end
      end
      S_VDIV: begin
        if (rsp.done) begin
          ival_nxt  = rsp.quot;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        intv_nxt = iv;
        if (elapsed >= {16'd0, iv}) begin
          pulse_nxt     = 1'b1;
          pos_nxt       = dir_r ? (pos_r + 32'd1) : (pos_r - 32'd1);
          last_step_nxt = now_r;
        end else begin
          pulse_nxt = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      integ_r       <= 64'd0;
      pos_r         <= 32'd0;
      prev_r        <= 32'd0;
      last_upd_r    <= 32'd0;
      last_step_r   <= 32'd0;
      dir_r         <= 1'b0;
      req_r.start   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      integ_r       <= integ_nxt;
      pos_r         <= pos_nxt;
      prev_r        <= prev_nxt;
      last_upd_r    <= last_upd_nxt;
      last_step_r   <= last_step_nxt;
      dir_r         <= dir_nxt;
      req_r.start   <= req_nxt.start;
    end
    req_r.op  <= req_nxt.op;
    req_r.a   <= req_nxt.a;
    req_r.b   <= req_nxt.b;
    angle_r   <= angle_nxt;
    now_r     <= now_nxt;
    tstep_r   <= tstep_nxt;
    err_r     <= err_nxt;
    dt_r      <= dt_nxt;
    pterm_r   <= pterm_nxt;
    iterm_r   <= iterm_nxt;
    dterm_r   <= dterm_nxt;
    sum_r     <= sum_nxt;
    ival_r    <= ival_nxt;
    rmag_r    <= rmag_nxt;
    num_neg_r <= num_neg_nxt;
    pulse_r   <= pulse_nxt;
    intv_r    <= intv_nxt;
    at_r      <= at_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_OUT);
  assign out_step_pulse       = pulse_r;
  assign out_direction        = dir_r;
  assign out_position         = pos_r;
  assign out_step_interval_us = intv_r;
  assign out_at_target        = at_r;

  `SPSG_ASSERT(a_no_take_while_result, !out_valid || in_stall, "input taken with result pending")
  `SPSG_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "ready after a transfer")
  `SPSG_ASSERT(a_target_quiet, !(out_valid && out_at_target) || (!out_step_pulse && out_step_interval_us == 16'd0), "step at target")
  `SPSG_ASSERT(a_alu_idle_start, !(req_r.start && (state_r == S_IDLE || state_r == S_OUT)), "unit started outside a tick")

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for stepper_pid_step_generator: directed table, then random ticks checked by a PID predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_SPR       = 3'd3,
    REG_MIN_IVAL  = 3'd4,
    REG_MAX_IVAL  = 3'd5,
    REG_SPEED     = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_e;

  typedef struct {
    bit        pulse;
    bit        dir;
    bit [31:0] pos;
    bit [15:0] ival;
    bit        at;
  } tick_res_t;

  typedef struct {
    int        angle;
    bit [31:0] now;
    bit        typed;
    tick_res_t res;
  } tick_row_t;

  localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
  localparam int WATCHDOG = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [31:0] in_target_angle, in_now_us;
  logic        out_step_pulse, out_direction, out_at_target;
  logic [31:0] out_position;
  logic [15:0] out_step_interval_us;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  stepper_pid_step_generator i_dut (.*);

  // controller copy
  longint    gp, gi, gd, spr;
  bit [15:0] min_iv, max_iv;
  bit [31:0] speed_k;
  bit [31:0] pos_q, last_upd, last_step;
  longint    integ;
  int        prev_err;
  bit        last_dir;

  tick_res_t pending[$];
  int        errors;
  int        idle_in, idle_out;
  int        quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic longint sat_mul(longint a, longint b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    if (p > $signed({64'd0, S64_MAX})) return S64_MAX;
    if (p < $signed({{64{1'b1}}, S64_MIN})) return S64_MIN;
    return p[63:0];
  endfunction

  function automatic void reset_model();
    gp = 131072; gi = 0; gd = 32768; spr = 2000;
    min_iv = 400; max_iv = 10000; speed_k = 20000;
    pos_q = 0; integ = 0; prev_err = 0; last_upd = 0; last_step = 0; last_dir = 0;
  endfunction

  function automatic void apply_reg(reg_idx_e idx, bit [31:0] v);
    case (idx)
      REG_GAIN_P:   gp = longint'($signed(v));
      REG_GAIN_I:   gi = longint'($signed(v));
      REG_GAIN_D:   gd = longint'($signed(v));
      REG_SPR:      spr = longint'(v[15:0]);
      REG_MIN_IVAL: min_iv = v[15:0];
      REG_MAX_IVAL: max_iv = v[15:0];
      REG_SPEED:    speed_k = v;
      default: ;
    endcase
  endfunction

  function automatic tick_res_t pid_tick(int angle, bit [31:0] now);
    tick_res_t r;
    longint tstep, err, dt, pterm, iterm, dterm, num, q, rm, outv;
    bit [63:0] mag, ival;
    r = '{default: 0};
    tstep = (longint'(angle) * spr) / 92160;
    err = tstep - longint'($signed(pos_q));
    if (err > 64'sd2147483647) err = 64'sd2147483647;
    if (err < -64'sd2147483648) err = -64'sd2147483648;
    if (err != 0) begin
      dt = longint'({32'd0, now - last_upd});
      if (dt == 0) dt = 100;
      last_upd = now;
      integ = sat_add(integ, err * dt);
      pterm = gp * err;
      q = integ / 1000000;
      rm = integ % 1000000;
      iterm = sat_add(sat_mul(gi, q), (gi * rm) / 1000000);
      num = gd * (err - longint'(prev_err));
      q = num / dt;
      rm = num % dt;
      dterm = sat_add(sat_mul(q, 1000000), (rm * 1000000) / dt);
      outv = sat_add(sat_add(pterm, iterm), dterm);
      prev_err = int'(err);
      last_dir = outv > 0;
      if (outv == S64_MIN) mag = S64_MAX;
      else mag = outv < 0 ? -outv : outv;
      if (mag > 64'd6553) ival = {16'd0, speed_k, 16'd0} / mag;
      else ival = {48'd0, max_iv};
      if (ival < {48'd0, min_iv}) ival = {48'd0, min_iv};
      if (ival > {48'd0, max_iv}) ival = {48'd0, max_iv};
      r.ival = ival[15:0];
      if ((now - last_step) >= ival[31:0]) begin
        r.pulse = 1'b1;
        pos_q = pos_q + (last_dir ? 32'd1 : 32'hffff_ffff);
        last_step = now;
      end
    end else begin
      integ = 0;
      r.at = 1'b1;
    end
    r.dir = last_dir;
    r.pos = pos_q;
    return r;
  endfunction

  task automatic send_tick(int angle, bit [31:0] now, bit typed, tick_res_t tr);
    tick_res_t p;
    @(negedge clk);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_angle <= angle;
    in_now_us <= now;
    do @(posedge clk); while (in_stall);
    p = pid_tick(angle, now);
    pending.push_back(typed ? tr : p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    apply_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < idle_out);

  always @(posedge clk) begin
    tick_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $realtime);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_step_pulse !== e.pulse) begin
          $display("%0t: step_pulse exp %0d got %0d", $realtime, e.pulse, out_step_pulse);
          errors++;
        end
        if (out_direction !== e.dir) begin
          $display("%0t: direction exp %0d got %0d", $realtime, e.dir, out_direction);
          errors++;
        end
        if (out_position !== e.pos) begin
          $display("%0t: position exp %0d got %0d", $realtime,
                   $signed(e.pos), $signed(out_position));
          errors++;
        end
        if (out_step_interval_us !== e.ival) begin
          $display("%0t: step_interval_us exp %0d got %0d", $realtime, e.ival,
                   out_step_interval_us);
          errors++;
        end
        if (out_at_target !== e.at) begin
          $display("%0t: at_target exp %0d got %0d", $realtime, e.at, out_at_target);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  tick_row_t dir_rows[] = '{
    '{0,            32'd0,          1'b1, '{0, 0, 32'd0, 16'd0,   1}},
    '{92160,        32'd0,          1'b1, '{0, 1, 32'd0, 16'd400, 0}},
    '{92160,        32'd500,        1'b0, '{default: 0}},
    '{92160,        32'd500,        1'b0, '{default: 0}},
    '{46,           32'd1200,       1'b0, '{default: 0}},
    '{-92160,       32'd2000,       1'b0, '{default: 0}},
    '{32'sh7fffffff, 32'd3000,      1'b0, '{default: 0}},
    '{32'sh80000000, 32'd4000,      1'b0, '{default: 0}},
    '{-1,           32'hffff_ff00,  1'b0, '{default: 0}},
    '{1,            32'hffff_ffff,  1'b0, '{default: 0}},
    '{-200,         32'd0,          1'b0, '{default: 0}},
    '{92,           32'd300,        1'b0, '{default: 0}},
    '{32'sh55555555, 32'haaaa_aaaa, 1'b0, '{default: 0}},
    '{32'shaaaaaaaa, 32'h5555_5555, 1'b0, '{default: 0}},
    '{0,            32'h6000_0000,  1'b0, '{default: 0}},
    '{0,            32'h6000_0100,  1'b0, '{default: 0}}
  };

  function automatic int near_angle();
    longint a;
    if (spr == 0 || $urandom_range(19) == 0) return int'($urandom);
    a = ((longint'($signed(pos_q)) + $signed($urandom_range(80)) - 40) * 92160) / spr;
    a = a + $signed($urandom_range(200)) - 100;
    if (a > 64'sd2147483647) a = 64'sd2147483647;
    if (a < -64'sd2147483648) a = -64'sd2147483648;
    return int'(a);
  endfunction

  initial begin
    bit [31:0] now;
    bit [31:0] regs[7];
    tick_res_t none;
    none = '{default: 0};
    errors = 0;
    quiet = 0;
    idle_in = 12;
    idle_out = 67;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_target_angle = '0;
    in_now_us = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_wdata = '0;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k])
      send_tick(dir_rows[k].angle, dir_rows[k].now, dir_rows[k].typed, dir_rows[k].res);
    drain();

    now = 32'h6000_1000;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin idle_in = 67; idle_out = 12; end
      if (ph == 6) begin idle_in = 0; idle_out = 0; end
      case (ph)
        1: regs = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff, 32'hffff,
                    32'hffff, 32'hffff_ffff};
        2: regs = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h1,
                    32'h1, 32'h0};
        3: regs = '{32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'd1600, 32'd5000,
                    32'd300, 32'd50000};
        default: begin
          regs[REG_GAIN_P] = $urandom_range(32'h0010_0000) - 32'h0002_0000;
          regs[REG_GAIN_I] = $urandom_range(32'h0004_0000) - 32'h0001_0000;
          regs[REG_GAIN_D] = $urandom_range(32'h0002_0000) - 32'h0000_8000;
          regs[REG_SPR] = $urandom_range(65535, 200);
          regs[REG_MIN_IVAL] = $urandom_range(2000, 1);
          regs[REG_MAX_IVAL] = $urandom_range(20000, regs[REG_MIN_IVAL]);
          regs[REG_SPEED] = $urandom;
        end
      endcase
      if (ph > 0) begin
        for (int r = 0; r < 7; r++) write_reg(reg_idx_e'(r), regs[r]);
        if (ph == 4) write_reg(REG_UNUSED, $urandom);
      end
      for (int n = 0; n < 180; n++) begin
        case ($urandom_range(19))
          0: now = $urandom;
          1: ;
          default: now = now + $urandom_range(3000);
        endcase
        send_tick(near_angle(), now, 1'b0, none);
      end
      drain();
    end

    repeat (700) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/spsg_pkg.sv
rtl/core/spsg_alu.sv
rtl/core/stepper_pid_step_generator.sv
tb/sv/tb_top.sv
